// ===== design/clock_page_replacer_top_macros.svh =====
// Assertion macros of the clock page replacer, used by cpr_ctrl.
`ifndef CLOCK_PAGE_REPLACER_TOP_MACROS_SVH
`define CLOCK_PAGE_REPLACER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define CPR_ASSERT_IMP(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and idle during reset.
`define CPR_ASSERT_NXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== design/cpr_pkg.sv =====
// Shared types and constants of the clock page replacer.
package cpr_pkg;

    localparam int FUNC_W         = 2;
    localparam int FRAME_W        = 6;
    localparam int COUNT_W        = 7;
    localparam int FRAME_SPAN     = 1 << FRAME_W;
    localparam int NUM_FRAMES_DEF = 64;

    localparam logic [FUNC_W-1:0] FUNC_VICTIM = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PIN    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_UNPIN  = 2'd2;

    // One frame entry of the ring.
    typedef struct packed {
        logic evictable;
        logic referenced;
    } entry_t;

    // Frame memory port controls.
    typedef struct packed {
        logic   re;
        logic   we;
        entry_t wdata;
    } ram_ctl_t;

endpackage

// ===== design/clock_page_replacer_top.sv =====
// Steps: pin and unpin read the entry, update it in S_RMW and go to S_DONE; a victim
// request scans up to NUM_FRAMES entries, one per cycle, then passes S_EVICT and S_DONE.
// Throughput: one request at a time; the next request is taken once the result is queued.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes every frame entry
// while no request is taken.
// Top level of the clock (second-chance) page replacer.
module clock_page_replacer_top #(
    parameter int NUM_FRAMES = cpr_pkg::NUM_FRAMES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [cpr_pkg::FUNC_W-1:0]   func,
    input  logic [cpr_pkg::FRAME_W-1:0]  frame,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         victim_found,
    output logic [cpr_pkg::FRAME_W-1:0]  victim_frame,
    output logic [cpr_pkg::COUNT_W-1:0]  evictable_count
);
    import cpr_pkg::*;

    localparam int IDX_W = $clog2(NUM_FRAMES);

    ram_ctl_t          ram_ctl;
    logic [IDX_W-1:0]  ram_waddr;
    logic [IDX_W-1:0]  ram_raddr;
    entry_t            ram_rdata;

    cpr_frame_ram #(
        .NUM_FRAMES(NUM_FRAMES)
    ) u_ram (
        .clk   (clk),
        .ctl   (ram_ctl),
        .waddr (ram_waddr),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cpr_ctrl #(
        .NUM_FRAMES(NUM_FRAMES)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .frame           (frame),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .victim_found    (victim_found),
        .victim_frame    (victim_frame),
        .evictable_count (evictable_count),
        .ram_ctl         (ram_ctl),
        .ram_waddr       (ram_waddr),
        .ram_raddr       (ram_raddr),
        .ram_rdata       (ram_rdata)
    );

endmodule

// ===== design/cpr_frame_ram.sv =====
// Frame state memory: one write port and one registered read port.
module cpr_frame_ram #(
    parameter int NUM_FRAMES = 64,
    localparam int IDX_W = $clog2(NUM_FRAMES)
) (
    input  logic              clk,
    input  cpr_pkg::ram_ctl_t ctl,
    input  logic [IDX_W-1:0]  waddr,
    input  logic [IDX_W-1:0]  raddr,
    output cpr_pkg::entry_t   rdata
);
    import cpr_pkg::*;

    entry_t mem [NUM_FRAMES];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[waddr] <= ctl.wdata;
        end
        if (ctl.re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/cpr_ctrl.sv =====
// Sequencer of the clock page replacer: clearing pass, request decode, ring scan and result register.
`include "clock_page_replacer_top_macros.svh"

module cpr_ctrl #(
    parameter int NUM_FRAMES = 64,
    localparam int IDX_W = $clog2(NUM_FRAMES)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [cpr_pkg::FUNC_W-1:0]     func,
    input  logic [cpr_pkg::FRAME_W-1:0]    frame,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           victim_found,
    output logic [cpr_pkg::FRAME_W-1:0]    victim_frame,
    output logic [cpr_pkg::COUNT_W-1:0]    evictable_count,
    output cpr_pkg::ram_ctl_t              ram_ctl,
    output logic [IDX_W-1:0]               ram_waddr,
    output logic [IDX_W-1:0]               ram_raddr,
    input  cpr_pkg::entry_t                ram_rdata
);
    import cpr_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FRAMES - 1);
    localparam int TOTAL_MAX = (NUM_FRAMES < FRAME_SPAN) ? NUM_FRAMES : FRAME_SPAN;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RMW,
        S_SCAN,
        S_EVICT,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     clr_idx_reg, clr_idx_next;
    logic [IDX_W-1:0]     hand_reg, hand_next;
    logic [COUNT_W-1:0]   total_reg, total_next;
    logic [IDX_W-1:0]     fidx_reg, fidx_next;
    logic                 unpin_reg, unpin_next;
    logic [IDX_W-1:0]     eval_idx_reg, eval_idx_next;
    logic [IDX_W-1:0]     iss_idx_reg, iss_idx_next;
    logic [IDX_W-1:0]     eval_cnt_reg, eval_cnt_next;
    logic                 cand_vld_reg, cand_vld_next;
    logic [IDX_W-1:0]     cand_reg, cand_next;
    logic [IDX_W-1:0]     vic_reg, vic_next;
    logic                 found_reg, found_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_found_reg, out_found_next;
    logic [FRAME_W-1:0]   out_frame_reg, out_frame_next;
    logic [COUNT_W-1:0]   out_count_reg, out_count_next;

    logic [IDX_W-1:0]     step_in;
    logic [IDX_W-1:0]     step_out;
    logic [IDX_W-1:0]     frame_idx;
    logic                 frame_in_range;

    assign frame_idx      = IDX_W'(frame);
    assign frame_in_range = 32'(frame) < 32'(NUM_FRAMES);

    // The one ring stepper, shared by the clearing pass, the scan and the hand update.
    always_comb
    begin
        case (state_reg)
            S_CLEAR: step_in = clr_idx_reg;
            S_SCAN:  step_in = iss_idx_reg;
            S_EVICT: step_in = vic_reg;
            default: step_in = hand_reg;
        endcase
    end

    assign step_out = (step_in == LAST_IDX) ? '0 : step_in + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        hand_next      = hand_reg;
        total_next     = total_reg;
        fidx_next      = fidx_reg;
        unpin_next     = unpin_reg;
        eval_idx_next  = eval_idx_reg;
        iss_idx_next   = iss_idx_reg;
        eval_cnt_next  = eval_cnt_reg;
        cand_vld_next  = cand_vld_reg;
        cand_next      = cand_reg;
        vic_next       = vic_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_frame_next = out_frame_reg;
        out_count_next = out_count_reg;
        ram_ctl        = '0;
        ram_waddr      = '0;
        ram_raddr      = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_ctl.we = 1'b1;
                ram_waddr  = clr_idx_reg;
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_idx_next = step_out;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    found_next = 1'b0;
                    vic_next   = '0;
                    case (func)
                        FUNC_VICTIM:
                        begin
                            if (total_reg != '0)
                            begin
                                ram_ctl.re    = 1'b1;
                                ram_raddr     = hand_reg;
                                eval_idx_next = hand_reg;
                                iss_idx_next  = step_out;
                                eval_cnt_next = '0;
                                cand_vld_next = 1'b0;
                                state_next    = S_SCAN;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        FUNC_PIN, FUNC_UNPIN:
                        begin
                            if (frame_in_range)
                            begin
                                ram_ctl.re = 1'b1;
                                ram_raddr  = frame_idx;
                                fidx_next  = frame_idx;
                                unpin_next = (func == FUNC_UNPIN);
                                state_next = S_RMW;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_RMW:
            begin
                ram_waddr = fidx_reg;
                if (unpin_reg)
                begin
                    ram_ctl.we               = 1'b1;
                    ram_ctl.wdata.evictable  = 1'b1;
                    ram_ctl.wdata.referenced = 1'b1;
                    if (!ram_rdata.evictable)
                    begin
                        total_next = total_reg + 1'b1;
                    end
                end
                else if (ram_rdata.evictable)
                begin
                    ram_ctl.we               = 1'b1;
                    ram_ctl.wdata.evictable  = 1'b0;
                    ram_ctl.wdata.referenced = ram_rdata.referenced;
                    total_next               = total_reg - 1'b1;
                end
                state_next = S_DONE;
            end

            S_SCAN:
            begin
                // The read data belongs to eval_idx; the next frame is fetched meanwhile.
                ram_ctl.re = 1'b1;
                ram_raddr  = iss_idx_reg;
                ram_waddr  = eval_idx_reg;
                if (ram_rdata.evictable && !ram_rdata.referenced)
                begin
                    vic_next   = eval_idx_reg;
                    state_next = S_EVICT;
                end
                else
                begin
                    if (ram_rdata.evictable)
                    begin
                        ram_ctl.we               = 1'b1;
                        ram_ctl.wdata.evictable  = 1'b1;
                        ram_ctl.wdata.referenced = 1'b0;
                        if (!cand_vld_reg)
                        begin
                            cand_vld_next = 1'b1;
                            cand_next     = eval_idx_reg;
                        end
                    end
                    if (eval_cnt_reg == LAST_IDX)
                    begin
                        // A full pass found only referenced frames: take the first one cleared.
                        vic_next   = cand_vld_reg ? cand_reg : eval_idx_reg;
                        state_next = S_EVICT;
                    end
                    else
                    begin
                        eval_idx_next = iss_idx_reg;
                        iss_idx_next  = step_out;
                        eval_cnt_next = eval_cnt_reg + 1'b1;
                    end
                end
            end

            S_EVICT:
            begin
                ram_ctl.we = 1'b1;
                ram_waddr  = vic_reg;
                total_next = total_reg - 1'b1;
                hand_next  = step_out;
                found_next = 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = found_reg;
                    out_frame_next = FRAME_W'(vic_reg);
                    out_count_next = total_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            hand_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            hand_reg      <= hand_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fidx_reg      <= fidx_next;
        unpin_reg     <= unpin_next;
        eval_idx_reg  <= eval_idx_next;
        iss_idx_reg   <= iss_idx_next;
        eval_cnt_reg  <= eval_cnt_next;
        cand_vld_reg  <= cand_vld_next;
        cand_reg      <= cand_next;
        vic_reg       <= vic_next;
        found_reg     <= found_next;
        out_found_reg <= out_found_next;
        out_frame_reg <= out_frame_next;
        out_count_reg <= out_count_next;
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign victim_found    = out_found_reg;
    assign victim_frame    = out_frame_reg;
    assign evictable_count = out_count_reg;

    `CPR_ASSERT_IMP(a_total_bound, 1'b1, 32'(total_reg) <= 32'(TOTAL_MAX),
        "evictable total exceeds the number of addressable frames")
    `CPR_ASSERT_IMP(a_evict_nonempty, state_reg == S_EVICT, total_reg != '0,
        "eviction started with no evictable frame")
    `CPR_ASSERT_IMP(a_victim_range, out_valid_reg && out_found_reg,
        32'(out_frame_reg) < 32'(NUM_FRAMES), "victim frame outside the ring")
    `CPR_ASSERT_IMP(a_no_victim_zero, out_valid_reg && !out_found_reg, out_frame_reg == '0,
        "victim frame nonzero without a victim")

endmodule

// ===== test/clock_page_replacer_top_test.sv =====
// Self-checking testbench of the clock page replacer: random handshake traffic against a predictor.
module clock_page_replacer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cpr_pkg::*;

    localparam int NUM_FRAMES = NUM_FRAMES_DEF;
    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
    localparam int RANDOM_ITEMS = 1800;
    localparam int CALM_TAIL = 200;
    localparam int LIMIT_CYCLES = 1_000_000;

    typedef struct packed {
        logic [FUNC_W-1:0]  op;
        logic [FRAME_W-1:0] frame_no;
    } replacer_req_t;

    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] victim;
        logic [COUNT_W-1:0] count;
    } replacer_answer_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [FUNC_W-1:0]  func = FUNC_VICTIM;
    logic [FRAME_W-1:0] frame = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               victim_found;
    logic [FRAME_W-1:0] victim_frame;
    logic [COUNT_W-1:0] evictable_count;

    // Shadow copy of the ring.
    logic               ring_evictable [NUM_FRAMES];
    logic               ring_referenced[NUM_FRAMES];
    int                 ring_hand;
    logic [COUNT_W-1:0] ring_total;

    replacer_req_t    request_q[$];
    replacer_answer_t answer_q[$];

    int error_count = 0;
    int cycle_count = 0;
    int in_gap_left = 0;
    int out_gap_left = 0;
    int in_idle_pct = 10;
    int out_idle_pct = 10;
    int accepted_count = 0;
    int result_count = 0;
    int random_count = 0;

    clock_page_replacer_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .frame          (frame),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .victim_found   (victim_found),
        .victim_frame   (victim_frame),
        .evictable_count(evictable_count)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic int pick_idle_pct();
        int r;
        r = $urandom_range(0, 2);
        return (r == 0) ? 0 : ((r == 1) ? 5 : 30);
    endfunction

    // Applies one request to the shadow ring and returns the answer it must produce.
    function automatic replacer_answer_t clock_step(input logic [FUNC_W-1:0] op,
                                                    input logic [FRAME_W-1:0] fr);
        replacer_answer_t ans;
        int idx;
        int i;
        int cand;
        int victim;
        bit have_cand;
        bit hit;

        ans = '0;
        have_cand = 0;
        hit = 0;
        cand = 0;
        victim = 0;
        if (op == FUNC_VICTIM)
        begin
            idx = ring_hand;
            for (i = 0; i < NUM_FRAMES && !hit; i++)
            begin
                if (ring_evictable[idx])
                begin
                    if (!ring_referenced[idx])
                    begin
                        victim = idx;
                        hit = 1;
                    end
                    else
                    begin
                        // Second chance: clear the bit and remember the first such frame.
                        ring_referenced[idx] = 1'b0;
                        if (!have_cand)
                        begin
                            have_cand = 1;
                            cand = idx;
                        end
                    end
                end
                if (!hit)
                    idx = (idx + 1 >= NUM_FRAMES) ? 0 : idx + 1;
            end
            if (!hit && have_cand)
            begin
                victim = cand;
                hit = 1;
            end
            if (hit)
            begin
                ring_evictable[victim] = 1'b0;
                ring_total = ring_total - 1'b1;
                ring_hand = (victim + 1 >= NUM_FRAMES) ? 0 : victim + 1;
                ans.found = 1'b1;
                ans.victim = FRAME_W'(victim);
            end
        end
        else if (op == FUNC_PIN)
        begin
            if (int'(fr) < NUM_FRAMES && ring_evictable[fr])
            begin
                ring_evictable[fr] = 1'b0;
                ring_total = ring_total - 1'b1;
            end
        end
        else if (op == FUNC_UNPIN)
        begin
            if (int'(fr) < NUM_FRAMES)
            begin
                if (!ring_evictable[fr])
                begin
                    ring_evictable[fr] = 1'b1;
                    ring_total = ring_total + 1'b1;
                end
                ring_referenced[fr] = 1'b1;
            end
        end
        ans.count = ring_total;
        return ans;
    endfunction

    task automatic queue_request(input logic [FUNC_W-1:0] op, input logic [FRAME_W-1:0] fr);
        replacer_req_t req;
        req.op = op;
        req.frame_no = fr;
        request_q.push_back(req);
    endtask

    // Request driver.
    always @(posedge clk)
    begin
        replacer_req_t req;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                answer_q.push_back(clock_step(func, frame));
                accepted_count++;
                if (accepted_count % 64 == 0)
                    in_idle_pct = pick_idle_pct();
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap_left > 0)
                begin
                    in_gap_left--;
                    in_valid <= 1'b0;
                end
                else if (request_q.size() == 0)
                    in_valid <= 1'b0;
                else if (request_q.size() > CALM_TAIL && $urandom_range(0, 99) < in_idle_pct)
                begin
                    in_gap_left = $urandom_range(0, 15);
                    in_valid <= 1'b0;
                end
                else
                begin
                    req = request_q.pop_front();
                    in_valid <= 1'b1;
                    func <= req.op;
                    frame <= req.frame_no;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        replacer_answer_t exp_ans;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                result_count++;
                if (result_count % 64 == 0)
                    out_idle_pct = pick_idle_pct();
                if (answer_q.size() == 0)
                    report_mismatch("result arrived with no request outstanding");
                else
                begin
                    exp_ans = answer_q.pop_front();
                    if (victim_found !== exp_ans.found)
                        report_mismatch($sformatf("victim_found %b, expected %b",
                                                  victim_found, exp_ans.found));
                    if (victim_frame !== exp_ans.victim)
                        report_mismatch($sformatf("victim_frame %0d, expected %0d",
                                                  victim_frame, exp_ans.victim));
                    if (evictable_count !== exp_ans.count)
                        report_mismatch($sformatf("evictable_count %0d, expected %0d",
                                                  evictable_count, exp_ans.count));
                end
            end
            if (out_gap_left > 0)
            begin
                out_gap_left--;
                out_ready <= 1'b0;
            end
            else if (request_q.size() > CALM_TAIL && $urandom_range(0, 99) < out_idle_pct)
            begin
                out_gap_left = $urandom_range(0, 15);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        wait (cycle_count == LIMIT_CYCLES);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int order[NUM_FRAMES];
        int i;
        int j;
        int n;
        int kind;
        int r;
        int tmp;
        logic [FUNC_W-1:0] op;
        logic [FRAME_W-1:0] fr;

        for (i = 0; i < NUM_FRAMES; i++)
        begin
            ring_evictable[i] = 1'b0;
            ring_referenced[i] = 1'b0;
        end
        ring_hand = 0;
        ring_total = '0;

        // Directed opening: empty ring, no-ops, repeated unpin, full pass with all bits set,
        // hand wrap-around, and frames with alternating bit patterns.
        queue_request(FUNC_VICTIM, 6'd0);
        queue_request(FUNC_PIN, 6'd0);
        queue_request(FUNC_NOP, 6'd63);
        queue_request(FUNC_UNPIN, 6'd0);
        queue_request(FUNC_UNPIN, 6'd63);
        queue_request(FUNC_UNPIN, 6'd63);
        queue_request(FUNC_UNPIN, 6'd5);
        queue_request(FUNC_VICTIM, 6'd0);
        queue_request(FUNC_VICTIM, 6'd63);
        queue_request(FUNC_UNPIN, 6'd5);
        queue_request(FUNC_PIN, 6'd5);
        queue_request(FUNC_PIN, 6'd5);
        queue_request(FUNC_VICTIM, 6'd0);
        queue_request(FUNC_VICTIM, 6'd0);
        queue_request(FUNC_UNPIN, 6'd42);
        queue_request(FUNC_UNPIN, 6'd21);
        queue_request(FUNC_NOP, 6'd42);
        queue_request(FUNC_VICTIM, 6'd0);
        queue_request(FUNC_UNPIN, 6'd63);
        queue_request(FUNC_VICTIM, 6'd0);
        queue_request(FUNC_VICTIM, 6'd0);
        queue_request(FUNC_VICTIM, 6'd0);

        while (random_count < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                // Fill the whole ring in random order, then evict a random number of frames.
                for (i = 0; i < NUM_FRAMES; i++)
                    order[i] = i;
                for (i = NUM_FRAMES - 1; i > 0; i--)
                begin
                    j = $urandom_range(0, i);
                    tmp = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                for (i = 0; i < NUM_FRAMES; i++)
                    queue_request(FUNC_UNPIN, FRAME_W'(order[i]));
                n = $urandom_range(1, 70);
                for (i = 0; i < n; i++)
                    queue_request(FUNC_VICTIM, FRAME_W'($urandom));
                random_count += NUM_FRAMES + n;
            end
            else if (kind == 1)
            begin
                n = $urandom_range(1, 20);
                for (i = 0; i < n; i++)
                    queue_request(FUNC_VICTIM, FRAME_W'($urandom));
                random_count += n;
            end
            else
            begin
                for (i = 0; i < 20; i++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        op = FUNC_UNPIN;
                    else if (r < 60)
                        op = FUNC_PIN;
                    else if (r < 95)
                        op = FUNC_VICTIM;
                    else
                        op = FUNC_NOP;
                    // A small hot set makes repeated pins and unpins of the same frame common.
                    if ($urandom_range(0, 1) == 0)
                        fr = FRAME_W'($urandom_range(0, 7));
                    else
                        fr = FRAME_W'($urandom);
                    queue_request(op, fr);
                end
                random_count += 20;
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (request_q.size() != 0 || in_valid || answer_q.size() != 0)
            @(posedge clk);
        repeat (NUM_FRAMES + 16) @(posedge clk);

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/cpr_pkg.sv
design/cpr_frame_ram.sv
design/cpr_ctrl.sv
design/clock_page_replacer_top.sv
test/clock_page_replacer_top_test.sv
